// File: rtl/core/lrut_pkg.sv
// Shared types and constants for the LRU replacement tracker.
package lrut_pkg;

    localparam int CFG_BITS = 7;
    localparam int OCC_BITS = 7;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd64;

    typedef struct packed {
        logic load;
        logic update;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

// File: rtl/core/lrut_ctrl.sv
// Controller: sequences lookup and update of one item at a time.
module lrut_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  lrut_pkg::status_t status,
    output lrut_pkg::cmd_t    cmd
);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_UPD  = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (!status.out_busy)
                begin
                    cmd.update = 1'b1;
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/core/lrut_datapath.sv
// Datapath: recency stack, parallel compare, shift and output register.
module lrut_datapath #(
    parameter int CAPACITY  = 64,
    parameter int PAGE_BITS = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  lrut_pkg::cmd_t                    cmd,
    output lrut_pkg::status_t                 status,
    input  logic [31:0]                       page,
    input  logic [lrut_pkg::CFG_BITS-1:0]     cfg_limit,
    output logic                              hit,
    output logic [lrut_pkg::OCC_BITS-1:0]     occupancy,
    output logic                              out_valid,
    input  logic                              out_stall
);

    localparam int PW = (PAGE_BITS < 32) ? PAGE_BITS : 32;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [PW-1:0] stack_reg [CAPACITY];
    logic [PW-1:0] key_reg;
    logic [CW-1:0] count_reg;
    logic [CAPACITY-1:0] match_reg;
    logic [CAPACITY-1:0] eq;
    logic [CAPACITY-1:0] below;
    logic [CAPACITY-1:0] shift_en;
    logic any_hit;
    logic [CW-1:0] lim;
    logic [CW-1:0] new_count;
    logic out_valid_reg;
    logic hit_reg;
    logic [lrut_pkg::OCC_BITS-1:0] occ_reg;

    assign status.out_busy = out_valid_reg && out_stall;

    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            eq[k] = (stack_reg[k] == page[PW-1:0]) && (CW'(k) < count_reg);
        end
    end

    always_comb
    begin
        logic [CW+7:0] c;
        c = (CW+8)'(cfg_limit);
        if (c == '0)
            c = (CW+8)'(1);
        if (c > (CW+8)'(CAPACITY))
            c = (CW+8)'(CAPACITY);
        lim = c[CW-1:0];
    end

    assign any_hit = |match_reg;

    always_comb
    begin
        logic seen;
        seen = 1'b0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            below[k] = ~seen;
            seen = seen | match_reg[k];
        end
        new_count = (count_reg >= lim) ? lim : count_reg + CW'(1);
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (any_hit)
                shift_en[k] = below[k];
            else
                shift_en[k] = (CW'(k) < new_count);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= page[PW-1:0];
            match_reg <= eq;
        end
        if (cmd.update)
        begin
            for (int k = 1; k < CAPACITY; k++)
            begin
                if (shift_en[k])
                    stack_reg[k] <= stack_reg[k-1];
            end
            stack_reg[0] <= key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update && !any_hit)
                count_reg <= new_count;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            hit_reg <= any_hit;
            occ_reg <= lrut_pkg::OCC_BITS'(any_hit ? count_reg : new_count);
        end
    end

    assign out_valid = out_valid_reg;
    assign hit = hit_reg;
    assign occupancy = occ_reg;

endmodule

// File: rtl/core/lru_replacement_tracker_unit.sv
// Top level of the LRU replacement tracker: fully associative LRU page cache.
// Input channel: page with in_valid/in_stall; a new item is taken only once
// the previous one has finished its update step. The load step latches the
// page and compares it against all resident stack entries in parallel; the
// update step shifts the stack and loads the result register. Output channel:
// hit and occupancy with out_valid/out_stall, one result per item, valid once
// the update step has loaded the result register. Items are taken one at a time
// because of the compare-then-shift sequence over the flip-flop stack.
// cfg_we/cfg_data write the number of entries in use (0 acts as 1, values
// above CAPACITY act as CAPACITY); write only while idle.
// Reset empties the cache and sets entries to 64. While the receiver
// stalls, the result holds, the item in flight waits in the update step and
// the input stalls.
// Shrinking the entry count keeps resident pages until the next miss.
module lru_replacement_tracker_unit #(
    parameter int CAPACITY  = 64,
    parameter int PAGE_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] page,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic [6:0]  occupancy,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data
);

    lrut_pkg::cmd_t    cmd;
    lrut_pkg::status_t status;
    logic [lrut_pkg::CFG_BITS-1:0] cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= lrut_pkg::CFG_RESET;
        else if (cfg_we)
            cfg_reg <= cfg_data;
    end

    lrut_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lrut_datapath #(
        .CAPACITY  (CAPACITY),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .page      (page),
        .cfg_limit (cfg_reg),
        .hit       (hit),
        .occupancy (occupancy),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    a_emit_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !cmd.load)
        else $error("load repeated without update");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occupancy != 7'd0))
        else $error("result with zero occupancy");

    a_no_emit_over: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !cmd.emit)
        else $error("result overwritten while stalled");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the LRU replacement tracker against a recency-stack model.
module testbench;

    localparam int CAP = 64;
    localparam int CYCLE_LIMIT = 400000;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [31:0]                   page;
    logic                          out_valid;
    logic                          out_stall;
    logic                          hit;
    logic [lrut_pkg::OCC_BITS-1:0] occupancy;
    logic                          cfg_we;
    logic [lrut_pkg::CFG_BITS-1:0] cfg_data;

    typedef struct packed {
        logic                          hit;
        logic [lrut_pkg::OCC_BITS-1:0] occupancy;
    } access_result_t;

    logic [31:0]                   lru_stack [CAP];
    int unsigned                   resident;
    logic [lrut_pkg::CFG_BITS-1:0] entries_cfg;
    access_result_t                pending_results [$];
    int                            errors;
    int                            hits_seen;
    int                            items_sent;
    longint                        cycles;
    int                            stall_pct;
    logic [31:0]                   hot_pages [8];

    lru_replacement_tracker_unit uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .page(page),
        .out_valid(out_valid), .out_stall(out_stall), .hit(hit), .occupancy(occupancy),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned entry_limit();
        int unsigned lim;
        lim = entries_cfg;
        if (lim == 0)
            lim = 1;
        if (lim > CAP)
            lim = CAP;
        return lim;
    endfunction

    function automatic access_result_t lookup_page(logic [31:0] pg);
        access_result_t r;
        int found;
        found = -1;
        for (int k = 0; k < resident; k++)
        begin
            if (found < 0 && lru_stack[k] == pg)
                found = k;
        end
        if (found >= 0)
        begin
            for (int k = found; k > 0; k--)
                lru_stack[k] = lru_stack[k-1];
            r.hit = 1'b1;
        end
        else
        begin
            if (resident >= entry_limit())
                resident = entry_limit() - 1;
            for (int k = resident; k > 0; k--)
                lru_stack[k] = lru_stack[k-1];
            resident++;
            r.hit = 1'b0;
        end
        lru_stack[0] = pg;
        r.occupancy = resident[lrut_pkg::OCC_BITS-1:0];
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** lru_replacement_tracker_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result hit=%0b occupancy=%0d", $time, hit, occupancy);
                errors++;
            end
            else
            begin
                access_result_t e;
                e = pending_results.pop_front();
                if (e.hit !== hit)
                begin
                    $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
                    errors++;
                end
                if (e.occupancy !== occupancy)
                begin
                    $display("%0t: occupancy expected %0d actual %0d", $time, e.occupancy,
                             occupancy);
                    errors++;
                end
                if (hit === 1'b1)
                    hits_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (stall_pct == 0)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 3)
            out_stall <= 1'b1;
        else if ($urandom_range(0, 99) < stall_pct)
            out_stall <= ($urandom_range(0, 3) != 0);
        else
            out_stall <= 1'b0;
    end

    task automatic send_page(logic [31:0] pg, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        page <= pg;
        pending_results.push_back(lookup_page(pg));
        items_sent++;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_entries(logic [lrut_pkg::CFG_BITS-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        entries_cfg = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_directed();
        send_page(32'h0000_0000, 0);
        send_page(32'hFFFF_FFFF, 0);
        send_page(32'hFFFF_FFFF, 0);
        send_page(32'h0000_0000, 0);
        send_page(32'hAAAA_5555, 1);
        send_page(32'h5555_AAAA, 1);
        send_page(32'h0000_0000, 0);
        for (int i = 0; i < 66; i++)
            send_page(32'h100 + i, 0);
        send_page(32'h101, 0);
        send_page(32'h141, 0);
    endtask

    task automatic test_shrink();
        write_entries(7'd3);
        send_page(32'h141, 0);
        send_page(32'h120, 0);
        send_page(32'hDEAD_BEEF, 0);
        send_page(32'h141, 0);
        write_entries(7'd0);
        send_page(32'h141, 0);
        send_page(32'h7, 0);
        send_page(32'h7, 0);
        write_entries(7'd127);
        for (int i = 0; i < 70; i++)
            send_page(32'h200 + i, 1);
        write_entries(7'd1);
        send_page(32'h7, 0);
    endtask

    task automatic test_random(int count, logic [lrut_pkg::CFG_BITS-1:0] ent);
        logic [31:0] pg;
        write_entries(ent);
        for (int i = 0; i < 8; i++)
            hot_pages[i] = $urandom;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0: pg = $urandom;
                1: pg = hot_pages[$urandom_range(0, 7)];
                default: pg = {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0,
                               8'($urandom_range(0, 79))};
            endcase
            send_page(pg, (i % 200) < 150);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        page = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        out_stall = 1'b0;
        errors = 0;
        hits_seen = 0;
        items_sent = 0;
        cycles = 0;
        stall_pct = 0;
        resident = 0;
        entries_cfg = lrut_pkg::CFG_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        stall_pct = 30;
        test_shrink();
        test_random(300, 7'd64);
        test_random(300, 7'd1);
        test_random(300, 7'd16);
        stall_pct = 0;
        test_random(300, 7'd64);
        stall_pct = 50;
        test_random(200, 7'd5);
        test_random(150, 7'd100);
        drain();
        $display("Ran %0d page accesses (%0d hits) over entry counts 0..127 with stalls.",
                 items_sent, hits_seen);
        if (errors == 0)
            $display("** lru_replacement_tracker_unit: PASSED **");
        else
            $display("** lru_replacement_tracker_unit: FAILED **");
        $finish;
    end
endmodule

// File: sim.f
rtl/core/lrut_pkg.sv
rtl/core/lrut_ctrl.sv
rtl/core/lrut_datapath.sv
rtl/core/lru_replacement_tracker_unit.sv
tb/sv/testbench.sv
